FILE: sv/stream_find_replace_defines.svh
// Assertion macros for the find-and-replace block.
// Used by the port checker; expects clk and rst_n in the including scope.
`ifndef STREAM_FIND_REPLACE_DEFINES_SVH
`define STREAM_FIND_REPLACE_DEFINES_SVH

// same-cycle implication, off while in reset
`define SFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define SFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also covers the reset cycles
`define SFR_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/sfr_pkg.sv
// Shared types, constants and match function for the find-and-replace block.
// No dependencies.
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int PATTERN_MAX = 8;
  localparam int REPLACE_MAX = 8;
  localparam int CNT_W       = 4;   // holds 0..8
  localparam int IDX_W       = 3;   // byte index 0..7
  localparam int WORD_W      = 64;
  localparam int ADDR_W      = 5;
  localparam int QDEPTH      = 2;

  localparam logic [WORD_W-1:0] PATTERN_RST = 64'h0000_0000_6163_6163; // "caca"
  localparam logic [CNT_W-1:0]  PLEN_RST    = 4'd4;
  localparam logic [WORD_W-1:0] REPLACE_RST = 64'h0000_0074_756f_7270; // "prout"
  localparam logic [CNT_W-1:0]  RLEN_RST    = 4'd5;

  // register indexes (byte address / 8)
  localparam logic [1:0] REG_PATTERN = 2'd0;
  localparam logic [1:0] REG_PLEN    = 2'd1;
  localparam logic [1:0] REG_REPLACE = 2'd2;
  localparam logic [1:0] REG_RLEN    = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_last;
  } out_item_t;

  // effective configuration, lengths already limited to 1..8
  typedef struct packed {
    logic [WORD_W-1:0] pattern;
    logic [CNT_W-1:0]  plen;
    logic [WORD_W-1:0] replace;
    logic [CNT_W-1:0]  rlen;
  } cfg_t;

  // one run of output bytes: byte 0 of word first
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  count;
    logic              last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [CNT_W-1:0] clamp_len(logic [CNT_W-1:0] v, int maxv);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = CNT_W'(1);
    else if (v > CNT_W'(maxv)) r = CNT_W'(maxv);
    return r;
  endfunction

  function automatic logic [7:0] byte_of(logic [WORD_W-1:0] w, logic [IDX_W-1:0] i);
    return w[{i, 3'b000} +: 8];
  endfunction

  // Longest prefix of the pattern that ends the held prefix (old_m bytes)
  // followed by c. Shift s aligns pattern byte j with held byte s+j; the
  // smallest shift that fits gives the longest match.
  function automatic logic [CNT_W-1:0] next_match(logic [WORD_W-1:0] pat,
                                                 logic [IDX_W-1:0] old_m,
                                                 logic [7:0] c);
    logic [CNT_W-1:0] m;
    logic [CNT_W-1:0] k;
    logic             ok;
    int               s;
    int               j;
    m = '0;
    for (s = PATTERN_MAX - 1; s >= 0; s--) begin
      if (IDX_W'(s) <= old_m) begin
        k  = {1'b0, old_m} + CNT_W'(1) - CNT_W'(s);
        ok = (byte_of(pat, IDX_W'(k - CNT_W'(1))) == c);
        for (j = 0; j < PATTERN_MAX - 1; j++) begin
          if (CNT_W'(j) < k - CNT_W'(1))
            ok = ok && (byte_of(pat, IDX_W'(j)) == byte_of(pat, IDX_W'(s + j)));
        end
        if (ok) m = k;
      end
    end
    return m;
  endfunction

endpackage

FILE: sv/sfr_cfg.sv
// Configuration registers behind the APB-style port.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfr_pkg::ADDR_W-1:0] paddr,
  input  logic [sfr_pkg::WORD_W-1:0] pwdata,
  output logic [sfr_pkg::WORD_W-1:0] prdata,
  output logic                       pready,
  output sfr_pkg::cfg_t              cfg
);
  import sfr_pkg::*;

  logic [WORD_W-1:0] pattern_r;
  logic [CNT_W-1:0]  plen_r;
  logic [WORD_W-1:0] replace_r;
  logic [CNT_W-1:0]  rlen_r;
  logic [1:0]        reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= PATTERN_RST;
      plen_r    <= PLEN_RST;
      replace_r <= REPLACE_RST;
      rlen_r    <= RLEN_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PATTERN: pattern_r <= pwdata;
        REG_PLEN:    plen_r    <= pwdata[CNT_W-1:0];
        REG_REPLACE: replace_r <= pwdata;
        REG_RLEN:    rlen_r    <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PATTERN: prdata = pattern_r;
      REG_PLEN:    prdata = {{(WORD_W-CNT_W){1'b0}}, plen_r};
      REG_REPLACE: prdata = replace_r;
      REG_RLEN:    prdata = {{(WORD_W-CNT_W){1'b0}}, rlen_r};
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    cfg.pattern = pattern_r;
    cfg.plen    = clamp_len(plen_r, PATTERN_MAX);
    cfg.replace = replace_r;
    cfg.rlen    = clamp_len(rlen_r, REPLACE_MAX);
  end

endmodule

FILE: sv/sfr_front.sv
// Front end: accepts text bytes, tracks the matched prefix and turns each
// byte into an output run (replacement or released text). Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  sfr_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  sfr_pkg::in_item_t in_data,
  input  sfr_pkg::q_status_t q_stat,
  output logic              push,
  output sfr_pkg::job_t     push_job
);
  import sfr_pkg::*;

  logic [CNT_W-1:0]  matched_r;
  logic [CNT_W-1:0]  matched_nxt;
  logic [IDX_W-1:0]  old_m;
  logic [CNT_W-1:0]  m;
  logic [CNT_W-1:0]  emit;
  logic [WORD_W-1:0] held_word;
  logic              accept;
  logic              last;
  int                i;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign last     = in_data.end_of_text;

  always_comb begin
    // a held prefix longer than the pattern allows is cut back to plen-1
    if (matched_r >= cfg.plen) old_m = IDX_W'(cfg.plen - CNT_W'(1));
    else                       old_m = IDX_W'(matched_r);

    m = next_match(cfg.pattern, old_m, in_data.in_byte);

    // held prefix with the new byte behind it
    held_word = cfg.pattern;
    for (i = 0; i < PATTERN_MAX; i++) begin
      if (IDX_W'(i) == old_m) held_word[i*8 +: 8] = in_data.in_byte;
    end

    emit          = {1'b0, old_m} + CNT_W'(1) - m;
    push_job.last = last;
    if (m == cfg.plen) begin
      push_job.word  = cfg.replace;
      push_job.count = cfg.rlen;
      matched_nxt    = '0;
    end else if (last) begin
      // released bytes plus the flushed prefix are the whole held text
      push_job.word  = held_word;
      push_job.count = {1'b0, old_m} + CNT_W'(1);
      matched_nxt    = '0;
    end else begin
      push_job.word  = held_word;
      push_job.count = emit;
      matched_nxt    = m;
    end
    push = accept && (push_job.count != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matched_r <= '0;
    end else if (accept) begin
      matched_r <= matched_nxt;
    end
  end

endmodule

FILE: sv/sfr_queue.sv
// Two-entry queue of output runs between front and back end.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sfr_pkg::job_t      push_job,
  input  logic               pop,
  output sfr_pkg::job_t      head,
  output sfr_pkg::q_status_t q_stat
);
  import sfr_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  job_t             entry_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W:0]   cnt_r;

  assign q_stat.full  = (cnt_r == (PTR_W+1)'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head         = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (PTR_W+1)'(1);
        2'b01:   cnt_r <= cnt_r - (PTR_W+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: sv/sfr_back.sv
// Back end: plays out one run at a time, one byte per cycle while out_stall is low.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  sfr_pkg::job_t      head,
  input  sfr_pkg::q_status_t q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output sfr_pkg::out_item_t out_data
);
  import sfr_pkg::*;

  job_t             job_r;
  logic             busy_r;
  logic [IDX_W-1:0] idx_r;
  logic             fire;
  logic             run_end;

  assign out_valid = busy_r;
  assign fire      = busy_r && !out_stall;
  assign run_end   = ({1'b0, idx_r} == job_r.count - CNT_W'(1));
  assign pop       = !q_stat.empty && (!busy_r || (fire && run_end));

  always_comb begin
    out_data.out_byte    = byte_of(job_r.word, idx_r);
    out_data.run_last    = run_end;
    out_data.stream_last = run_end && job_r.last;
  end

  always_ff @(posedge clk) begin
    if (pop) job_r <= head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (fire) begin
      if (run_end) busy_r <= 1'b0;
      else         idx_r  <= idx_r + IDX_W'(1);
    end
  end

endmodule

FILE: sv/stream_find_replace.sv
// Streaming find-and-replace-all: top level joining config, front end,
// run queue and back end. Depends on sfr_pkg and the sfr_* modules.
//
// Takes one text byte per cycle and replaces every leftmost, non-overlapping
// occurrence of the pattern (1..8 bytes) with the replacement (1..8 bytes).
// Each input byte is classified in the cycle it is accepted and becomes a run
// of 0 to 8 output bytes; runs leave at one byte per cycle while out_stall is
// low, and a run of released text or of the replacement holds the output side
// until it has played out. A two-run queue sits between the sides, so the input
// keeps taking one byte per cycle while runs are a single byte long and stalls
// only when two runs are waiting. A byte flagged end_of_text flushes any held
// partial match and marks its last output with stream_last. A run passes through
// the queue and the back end's run register. Config is APB at byte address 8*i.
`timescale 1ns / 1ps

module stream_find_replace (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  sfr_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output sfr_pkg::out_item_t         out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sfr_pkg::ADDR_W-1:0] paddr,
  input  logic [sfr_pkg::WORD_W-1:0] pwdata,
  output logic [sfr_pkg::WORD_W-1:0] prdata,
  output logic                       pready
);
  import sfr_pkg::*;

  cfg_t      cfg;
  q_status_t q_stat;
  job_t      push_job;
  job_t      head;
  logic      push;
  logic      pop;

  sfr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  sfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  sfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: sv/sfr_checker.sv
// Port-level checks for the find-and-replace block, bound to the top level.
// Depends on sfr_pkg and stream_find_replace_defines.svh.
`timescale 1ns / 1ps
`include "stream_find_replace_defines.svh"

module sfr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input sfr_pkg::out_item_t out_data
);
  import sfr_pkg::*;

  `SFR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "item moved")
  `SFR_ASSERT_IMP(a_stream_end, out_valid && out_data.stream_last, out_data.run_last, "bad end")
  // a run is played out without gaps
  `SFR_ASSERT_NXT(a_run_gapless, out_valid && !out_stall && !out_data.run_last, out_valid, "gap")
  `SFR_ASSERT_RST(a_reset_idle, !rst_n, !out_valid && !in_stall, "not idle after reset")

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (.*);
